// File: hdl/card_number_luhn_classifier_macros.svh
// Assertion macros used by the card number classifier checker.
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_MACROS_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define CNLC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("card classifier assertion failed");

// Next-cycle implication, also checked through reset.
`define CNLC_ASSERT_NEXT(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("card classifier assertion failed");

`endif

// File: hdl/cnlc_pkg.sv
// Shared constants and types of the card number Luhn classifier.
package cnlc_pkg;

   localparam int CARD_BITS      = 54;
   localparam int DIGITS         = 16;
   localparam int BCD_BITS       = 4 * DIGITS;
   localparam int BITS_PER_STAGE = 6;
   localparam int BCD_STAGES     = CARD_BITS / BITS_PER_STAGE;
   // input register, converter stages, digit-sum stage, output register
   localparam int LATENCY        = BCD_STAGES + 3;

   typedef logic [CARD_BITS-1:0] card_type;

   localparam card_type POW12 = 54'd1000000000000;
   localparam card_type POW13 = 54'd10000000000000;
   localparam card_type POW14 = 54'd100000000000000;
   localparam card_type POW15 = 54'd1000000000000000;
   localparam card_type POW16 = 54'd10000000000000000;

   typedef enum logic [1:0] {
      BRAND_INVALID    = 2'd0,
      BRAND_VISA       = 2'd1,
      BRAND_AMEX       = 2'd2,
      BRAND_MASTERCARD = 2'd3
   } brand_type;

endpackage

// File: hdl/card_number_luhn_classifier.sv
// Card number classifier: pipelined binary-to-BCD, Luhn check and brand decode.
//
// One card number (54-bit binary) enters per transaction when start is high
// and busy is low; busy is high only while reset is applied and in the cycle
// after it, so a new number may enter on every clock. Each number gives one
// result, shown on rsp_brand for exactly one cycle with rsp_valid high.
// Results come out in the order the numbers went in and never wait: the
// receiver must take rsp_brand in the cycle rsp_valid is high. A number
// passes through an input register, the binary-to-decimal converter (a
// double-dabble pipeline of 9 stages that each shift in 6 bits), a digit-sum
// stage and the output register. brand: 0 invalid, 1 visa, 2 amex, 3 mastercard.
module card_number_luhn_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [cnlc_pkg::CARD_BITS-1:0] req_card_number,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_brand
);

   // digit count class, decided up front by range compares
   typedef enum logic [2:0] {
      LEN_OTHER,
      LEN_13,
      LEN_14,
      LEN_15,
      LEN_16
   } len_type;

   typedef struct packed {
      logic [cnlc_pkg::BCD_BITS-1:0]  bcd;
      logic [cnlc_pkg::CARD_BITS-1:0] bin;
   } dd_type;

   // Six double-dabble steps: adjust every digit of 5 or more by 3, then
   // shift the next binary bit into the BCD word. The carry out of the top
   // digit is dropped; such numbers are already out of range.
   function automatic dd_type dd_step(input dd_type cur);
      dd_type nxt;
      nxt = cur;
      for (int s = 0; s < cnlc_pkg::BITS_PER_STAGE; s++) begin
         for (int d = 0; d < cnlc_pkg::DIGITS; d++) begin
            if (nxt.bcd[4*d +: 4] >= 4'd5) begin
               nxt.bcd[4*d +: 4] = nxt.bcd[4*d +: 4] + 4'd3;
            end
         end
         nxt.bcd = {nxt.bcd[cnlc_pkg::BCD_BITS-2:0], nxt.bin[cnlc_pkg::CARD_BITS-1]};
         nxt.bin = {nxt.bin[cnlc_pkg::CARD_BITS-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // Luhn weight of one digit: every second digit from the right is doubled,
   // and a double of 10 or more is folded to one digit.
   function automatic logic [3:0] luhn_digit(input logic [3:0] dig, input logic dbl);
      logic [4:0] twice;
      twice = {dig, 1'b0};
      if (!dbl) begin
         return dig;
      end else if (twice >= 5'd10) begin
         return 4'(twice - 5'd9);
      end else begin
         return twice[3:0];
      end
   endfunction

   // ------------------------------------------------------------------
   // Accept and range classification
   // ------------------------------------------------------------------
   logic busy_ff;
   logic accept;
   len_type len_in;

   logic                           s0_valid_ff;
   logic [cnlc_pkg::CARD_BITS-1:0] s0_bin_ff;
   len_type                        s0_len_ff;

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   always_comb begin
      if (req_card_number < cnlc_pkg::POW12 || req_card_number >= cnlc_pkg::POW16) begin
         len_in = LEN_OTHER;
      end else if (req_card_number < cnlc_pkg::POW13) begin
         len_in = LEN_13;
      end else if (req_card_number < cnlc_pkg::POW14) begin
         len_in = LEN_14;
      end else if (req_card_number < cnlc_pkg::POW15) begin
         len_in = LEN_15;
      end else begin
         len_in = LEN_16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         s0_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= 1'b0;
         s0_valid_ff <= accept;
      end
      s0_bin_ff <= req_card_number;
      s0_len_ff <= len_in;
   end

   // ------------------------------------------------------------------
   // Binary-to-BCD pipeline
   // ------------------------------------------------------------------
   logic [cnlc_pkg::BCD_STAGES-1:0] bcd_valid_ff;
   dd_type                          bcd_ff [cnlc_pkg::BCD_STAGES];
   len_type                         bcd_len_ff [cnlc_pkg::BCD_STAGES];
   dd_type                          bcd_in [cnlc_pkg::BCD_STAGES];

   always_comb begin
      bcd_in[0] = dd_step('{bcd: '0, bin: s0_bin_ff});
      for (int st = 1; st < cnlc_pkg::BCD_STAGES; st++) begin
         bcd_in[st] = dd_step(bcd_ff[st-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bcd_valid_ff <= '0;
      end else begin
         bcd_valid_ff <= {bcd_valid_ff[cnlc_pkg::BCD_STAGES-2:0], s0_valid_ff};
      end
      bcd_len_ff[0] <= s0_len_ff;
      for (int st = 1; st < cnlc_pkg::BCD_STAGES; st++) begin
         bcd_len_ff[st] <= bcd_len_ff[st-1];
      end
      for (int st = 0; st < cnlc_pkg::BCD_STAGES; st++) begin
         bcd_ff[st] <= bcd_in[st];
      end
   end

   // ------------------------------------------------------------------
   // Luhn digit weighting and partial sums (four groups of four digits)
   // ------------------------------------------------------------------
   localparam int GROUPS = cnlc_pkg::DIGITS / 4;

   logic [cnlc_pkg::BCD_BITS-1:0] digits;
   logic [5:0]                    grp_in [GROUPS];

   logic       sum_valid_ff;
   logic [5:0] sum_grp_ff [GROUPS];
   len_type    sum_len_ff;
   logic [15:0] sum_lead_ff;   // digits 15 down to 12

   assign digits = bcd_ff[cnlc_pkg::BCD_STAGES-1].bcd;

   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < 4; k++) begin
            grp_in[g] = grp_in[g] + 6'(luhn_digit(digits[4*(4*g+k) +: 4], k[0]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
      end else begin
         sum_valid_ff <= bcd_valid_ff[cnlc_pkg::BCD_STAGES-1];
      end
      for (int g = 0; g < GROUPS; g++) begin
         sum_grp_ff[g] <= grp_in[g];
      end
      sum_len_ff  <= bcd_len_ff[cnlc_pkg::BCD_STAGES-1];
      sum_lead_ff <= digits[cnlc_pkg::BCD_BITS-1 -: 16];
   end

   // ------------------------------------------------------------------
   // Checksum test and brand decode
   // ------------------------------------------------------------------
   logic [7:0]          total;
   logic                luhn_ok;
   logic [3:0]          d15, d14, d13, d12;
   cnlc_pkg::brand_type brand_in;

   logic                rsp_valid_ff;
   cnlc_pkg::brand_type rsp_brand_ff;

   assign d15 = sum_lead_ff[15:12];
   assign d14 = sum_lead_ff[11:8];
   assign d13 = sum_lead_ff[7:4];
   assign d12 = sum_lead_ff[3:0];

   always_comb begin
      total = '0;
      for (int g = 0; g < GROUPS; g++) begin
         total = total + 8'(sum_grp_ff[g]);
      end
      // total is at most 144: test against each multiple of ten
      luhn_ok = 1'b0;
      for (int k = 0; k <= 14; k++) begin
         if (total == 8'(k * 10)) begin
            luhn_ok = 1'b1;
         end
      end
   end

   always_comb begin
      brand_in = cnlc_pkg::BRAND_INVALID;
      if (luhn_ok) begin
         case (sum_len_ff)
            LEN_13: begin
               if (d12 == 4'd4) begin
                  brand_in = cnlc_pkg::BRAND_VISA;
               end
            end
            LEN_15: begin
               if (d14 == 4'd3 && (d13 == 4'd4 || d13 == 4'd7)) begin
                  brand_in = cnlc_pkg::BRAND_AMEX;
               end
            end
            LEN_16: begin
               if (d15 == 4'd5 && d14 >= 4'd1 && d14 <= 4'd5) begin
                  brand_in = cnlc_pkg::BRAND_MASTERCARD;
               end else if (d15 == 4'd4) begin
                  brand_in = cnlc_pkg::BRAND_VISA;
               end
            end
            default: begin
               brand_in = cnlc_pkg::BRAND_INVALID;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sum_valid_ff;
      end
      rsp_brand_ff <= brand_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_brand = rsp_brand_ff;

endmodule

// File: hdl/cnlc_checker.sv
// Port-level checker for the card number classifier, with its bind.
`include "card_number_luhn_classifier_macros.svh"

module cnlc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [cnlc_pkg::CARD_BITS-1:0] req_card_number,
   input logic                           rsp_valid,
   input logic [1:0]                     rsp_brand
);

   // no transaction is taken right after reset, and the pipe comes up empty
   `CNLC_ASSERT_NEXT(busy_after_reset, clock, reset, busy)
   `CNLC_ASSERT_NEXT(idle_after_reset, clock, reset, !rsp_valid)

   // every transaction gives exactly one result, and no result comes without one
   `CNLC_ASSERT_SAME(result_follows, clock, reset, start && !busy, ##(cnlc_pkg::LATENCY) rsp_valid)
   `CNLC_ASSERT_SAME(no_stray_result, clock, reset, rsp_valid, $past(start && !busy, cnlc_pkg::LATENCY))

   // numbers of fewer than 13 digits are always invalid
   `CNLC_ASSERT_SAME(short_invalid, clock, reset, start && !busy && req_card_number < cnlc_pkg::POW12, ##(cnlc_pkg::LATENCY) rsp_brand == cnlc_pkg::BRAND_INVALID)

endmodule

bind card_number_luhn_classifier cnlc_checker u_cnlc_checker (.*);
